[sv/clx_pkg.sv]
// clx_pkg: shared types, character codes and the keyword table of the C token lexer.
// Stands alone; every lexer file refers to it by scoped names.
package clx_pkg;

   // Largest number of word bytes ever kept, whatever MAX_WORD says.
   localparam int WORD_CAP_MAX = 40;

   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
   localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

   // Token kinds on the result channel.
   localparam logic [2:0] TOK_NUMBER  = 3'd0;
   localparam logic [2:0] TOK_KEYWORD = 3'd1;
   localparam logic [2:0] TOK_IDENT   = 3'd2;
   localparam logic [2:0] TOK_SYMBOL  = 3'd3;
   localparam logic [2:0] TOK_END     = 3'd4;

   // Characters with a meaning of their own.
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_SKIP,
      MODE_NUM,
      MODE_WORD
   } lex_mode_type;

   typedef enum logic [1:0] {
      FL_NONE,
      FL_NUMBER,
      FL_WORD
   } flush_kind_type;

   typedef enum logic [1:0] {
      TL_NONE,
      TL_SYMBOL,
      TL_END
   } tail_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WORD,
      BK_TAIL
   } back_state_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [30:0] number_value;
      logic        number_overflow;
      logic [4:0]  keyword_index;
      logic [63:0] text_chunk;
      logic [3:0]  chunk_bytes;
      logic        word_truncated;
      logic [7:0]  symbol_byte;
      logic [31:0] line_total;
      logic        last;
   } rsp_type;

   // One command per input byte that causes results: an optional flush of
   // the pending token, then an optional symbol or end report.
   typedef struct packed {
      flush_kind_type flush;
      tail_kind_type  tail;
      logic [30:0]    num_value;
      logic           num_sat;
      logic [5:0]     word_len;
      logic           word_ovf;
      logic [7:0]     sym;
      logic [31:0]    line_total;
   } cmd_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] index;
   } kw_hit_type;

   // Keywords, right-justified with the first character most significant.
   localparam logic [63:0] KW_NAMES [32] = '{
      "auto", "default", "signed", "enum", "extern", "for", "register", "if",
      "else", "int", "while", "do", "break", "continue", "double", "float",
      "return", "char", "case", "const", "sizeof", "long", "short", "typedef",
      "switch", "unsigned", "void", "static", "struct", "goto", "union",
      "volatile"
   };

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // Match the first len bytes of text (first byte in the low bits).
   function automatic kw_hit_type kw_lookup(input logic [63:0] text, input logic [5:0] len);
      logic [63:0] word;
      logic [2:0]  src;
      kw_hit_type  r;
      word = '0;
      r    = '0;
      for (int p = 0; p < 8; p++) begin
         src = 3'(len - 6'(p) - 6'd1);
         if (6'(p) < len) begin
            word[8*p +: 8] = text[8*src +: 8];
         end
      end
      if ((len != 6'd0) && (len <= 6'd8)) begin
         for (int k = 0; k < 32; k++) begin
            if (!r.hit && (word == KW_NAMES[k])) begin
               r.hit   = 1'b1;
               r.index = 5'(k);
            end
         end
      end
      return r;
   endfunction

endpackage

[sv/c_token_lexer.sv]
// c_token_lexer: C token lexer, top level.
// Instantiates clx_front, clx_cmd_fifo and clx_back; uses clx_pkg.
//
// Usage:
//   Input channel: one source byte per beat on req_data (char_byte), taken
//   when push is high and full is low. A beat with end_of_input set carries
//   no character: it flushes the pending token, adds an end report with the
//   line total and returns the lexer to its reset state for a new text.
//   Result channel: a beat is shown while empty is low and taken with pop.
//   The last beat caused by one input byte has last set.
// Path: a number, symbol or end report passes through the command queue
//   and the output register; an identifier or keyword also waits for the
//   registered word buffer read, then comes one chunk per cycle while the receiver pops.
// Throughput: one byte per cycle while full is low. After a word ends the
//   front holds full high until the back has read the word buffer (the
//   keyword beat, or every chunk of an identifier), since the single word
//   buffer is shared by both halves.
//   The two-entry command queue absorbs short bursts of results.
// Stall: when the receiver does not pop, the output register holds its beat,
//   the back holds, the command queue fills and full rises.
// Reset: synchronous, active high; clears all control state, no clear pass.
module c_token_lexer #(
   parameter int MAX_WORD = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  clx_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output clx_pkg::rsp_type  rsp_data
);

   // Word buffer geometry: at most 40 bytes kept, read back in 8-byte rows.
   localparam int WORD_CAP  = (MAX_WORD < clx_pkg::WORD_CAP_MAX) ? MAX_WORD
                                                                  : clx_pkg::WORD_CAP_MAX;
   localparam int WORD_ROWS = (WORD_CAP + 7) / 8;
   localparam int ROW_W     = (WORD_ROWS > 1) ? $clog2(WORD_ROWS) : 1;

   clx_pkg::cmd_type cmd_wr_data, cmd_rd_data;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic             word_done;
   logic [ROW_W-1:0] rd_row;
   logic [63:0]      rd_data;

   // Front: classify bytes, build tokens, issue one command per result group.
   clx_front #(
      .MAX_WORD (MAX_WORD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_wr_data),
      .word_done (word_done),
      .rd_row    (rd_row),
      .rd_data   (rd_data)
   );

   // Decouple the byte side from the result side.
   clx_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr_data),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   // Back: expand commands into result beats, keyword match, chunking.
   clx_back #(
      .MAX_WORD (MAX_WORD)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rd_data),
      .rd_row    (rd_row),
      .rd_data   (rd_data),
      .word_done (word_done),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/clx_cmd_fifo.sv]
// clx_cmd_fifo: two-entry command queue between lexer front and back.
// Uses clx_pkg::cmd_type.
module clx_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  clx_pkg::cmd_type  wr_data,
   output logic              full,
   input  logic              rd_en,
   output clx_pkg::cmd_type  rd_data,
   output logic              empty
);

   clx_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[sv/clx_front.sv]
// clx_front: accepts source bytes, tracks the token in progress, keeps the word
// buffer and issues flush/symbol/end commands. Uses clx_pkg.
module clx_front #(
   parameter int MAX_WORD = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  clx_pkg::req_type  req_data,
   input  logic              cmd_full,
   output logic              cmd_push,
   output clx_pkg::cmd_type  cmd_data,
   input  logic              word_done,
   input  logic [((((MAX_WORD < clx_pkg::WORD_CAP_MAX) ? MAX_WORD : clx_pkg::WORD_CAP_MAX)
                  + 7) / 8 > 1 ? $clog2((((MAX_WORD < clx_pkg::WORD_CAP_MAX) ? MAX_WORD
                  : clx_pkg::WORD_CAP_MAX) + 7) / 8) : 1) - 1:0] rd_row,
   output logic [63:0]       rd_data
);

   localparam int WORD_CAP  = (MAX_WORD < clx_pkg::WORD_CAP_MAX) ? MAX_WORD
                                                                  : clx_pkg::WORD_CAP_MAX;
   localparam int WORD_ROWS = (WORD_CAP + 7) / 8;
   localparam int ROW_W     = (WORD_ROWS > 1) ? $clog2(WORD_ROWS) : 1;

   clx_pkg::lex_mode_type mode_ff, mode_in;
   logic [30:0] acc_ff, acc_in;
   logic        sat_ff, sat_in;
   logic [5:0]  len_ff, len_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] line_ff, line_in;
   logic        busy_ff, busy_in;

   logic [7:0][7:0] word_mem [WORD_ROWS];
   logic [63:0]     rd_data_ff;

   logic [7:0]  c;
   logic        accept, digit, letter, word_char, consumed;
   logic [34:0] prod;
   logic        wr_en;
   logic [5:0]  wr_idx;
   clx_pkg::cmd_type cmd;

   assign full    = cmd_full | busy_ff;
   assign accept  = push & ~full;
   assign c       = req_data.char_byte;
   assign digit   = clx_pkg::is_digit(c);
   assign letter  = clx_pkg::is_letter(c);
   assign word_char = digit | letter | (c == clx_pkg::CH_UNDER) | (c == clx_pkg::CH_DOLLAR);
   // acc * 10 + digit
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {31'd0, c[3:0]};
   assign rd_data = rd_data_ff;

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      line_in  = line_ff;
      busy_in  = busy_ff & ~word_done;
      wr_en    = 1'b0;
      wr_idx   = len_ff;
      consumed = 1'b0;
      cmd            = '0;
      cmd.flush      = clx_pkg::FL_NONE;
      cmd.tail       = clx_pkg::TL_NONE;
      cmd.num_value  = acc_ff;
      cmd.num_sat    = sat_ff;
      cmd.word_len   = len_ff;
      cmd.word_ovf   = ovf_ff;
      cmd.sym        = c;
      cmd.line_total = line_ff;

      if (accept && req_data.end_of_input) begin
         // Flush the pending token, report, and return to the reset state.
         if (mode_ff == clx_pkg::MODE_NUM) begin
            cmd.flush = clx_pkg::FL_NUMBER;
         end else if (mode_ff == clx_pkg::MODE_WORD) begin
            cmd.flush = clx_pkg::FL_WORD;
         end
         cmd.tail = clx_pkg::TL_END;
         mode_in  = clx_pkg::MODE_IDLE;
         acc_in   = '0;
         sat_in   = 1'b0;
         len_in   = '0;
         ovf_in   = 1'b0;
         line_in  = '0;
      end else if (accept) begin
         case (mode_ff)
            clx_pkg::MODE_NUM: begin
               if (digit) begin
                  consumed = 1'b1;
                  if (prod > {4'd0, clx_pkg::NUM_MAX}) begin
                     acc_in = clx_pkg::NUM_MAX;
                     sat_in = 1'b1;
                  end else begin
                     acc_in = prod[30:0];
                  end
               end else begin
                  cmd.flush = clx_pkg::FL_NUMBER;
               end
            end
            clx_pkg::MODE_WORD: begin
               if (word_char) begin
                  consumed = 1'b1;
                  if (len_ff < 6'(WORD_CAP)) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + 6'd1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  cmd.flush = clx_pkg::FL_WORD;
               end
            end
            clx_pkg::MODE_SKIP: begin
               consumed = (c != clx_pkg::CH_NL);
            end
            default: begin
            end
         endcase

         // The byte that ends a token is lexed in its own right.
         if (!consumed) begin
            mode_in = clx_pkg::MODE_IDLE;
            if (c == clx_pkg::CH_HASH) begin
               mode_in = clx_pkg::MODE_SKIP;
            end else if (digit) begin
               mode_in = clx_pkg::MODE_NUM;
               acc_in  = {27'd0, c[3:0]};
               sat_in  = 1'b0;
            end else if (letter) begin
               mode_in = clx_pkg::MODE_WORD;
               wr_en   = 1'b1;
               wr_idx  = 6'd0;
               len_in  = 6'd1;
               ovf_in  = 1'b0;
            end else if ((c == clx_pkg::CH_SPACE) || (c == clx_pkg::CH_TAB)) begin
            end else if (c == clx_pkg::CH_NL) begin
               if (line_ff != clx_pkg::LINE_MAX) begin
                  line_in = line_ff + 32'd1;
               end
            end else begin
               cmd.tail = clx_pkg::TL_SYMBOL;
            end
         end
      end

      cmd_push = accept & ((cmd.flush != clx_pkg::FL_NONE) || (cmd.tail != clx_pkg::TL_NONE));
      // Hold the word buffer until the back has read every chunk of it.
      if (cmd_push && (cmd.flush == clx_pkg::FL_WORD)) begin
         busy_in = 1'b1;
      end
   end

   assign cmd_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= clx_pkg::MODE_IDLE;
         acc_ff  <= '0;
         sat_ff  <= 1'b0;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         line_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         sat_ff  <= sat_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
         line_ff <= line_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[wr_idx[ROW_W+2:3]][wr_idx[2:0]] <= c;
      end
      rd_data_ff <= word_mem[rd_row];
   end

   wr_while_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy_ff)
      else $error("word buffer written while the back reads it");

   word_not_empty: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == clx_pkg::MODE_WORD) |-> (len_ff != 6'd0))
      else $error("word mode with empty word buffer");

endmodule

[sv/clx_back.sv]
// clx_back: expands queued commands into result beats (number, keyword,
// identifier chunks, symbol, end report) through a one-beat output register.
// Uses clx_pkg; reads the word buffer held in clx_front.
module clx_back #(
   parameter int MAX_WORD = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  clx_pkg::cmd_type  cmd_data,
   output logic [((((MAX_WORD < clx_pkg::WORD_CAP_MAX) ? MAX_WORD : clx_pkg::WORD_CAP_MAX)
                  + 7) / 8 > 1 ? $clog2((((MAX_WORD < clx_pkg::WORD_CAP_MAX) ? MAX_WORD
                  : clx_pkg::WORD_CAP_MAX) + 7) / 8) : 1) - 1:0] rd_row,
   input  logic [63:0]       rd_data,
   output logic              word_done,
   output logic              empty,
   input  logic              pop,
   output clx_pkg::rsp_type  rsp_data
);

   localparam int WORD_CAP  = (MAX_WORD < clx_pkg::WORD_CAP_MAX) ? MAX_WORD
                                                                  : clx_pkg::WORD_CAP_MAX;
   localparam int WORD_ROWS = (WORD_CAP + 7) / 8;
   localparam int ROW_W     = (WORD_ROWS > 1) ? $clog2(WORD_ROWS) : 1;

   clx_pkg::back_state_type state_ff, state_in;
   logic [ROW_W-1:0] chunk_ff, chunk_in;
   logic             valid_ff, valid_in;
   clx_pkg::rsp_type rsp_ff, res;
   logic             load;

   logic             adv, have, last_chunk, word_end, kw_now, tail_none;
   logic [5:0]       rem;
   logic [3:0]       nbytes;
   logic [63:0]      chunk_text;
   clx_pkg::kw_hit_type kw;
   clx_pkg::rsp_type base, tail_res;

   assign adv       = ~valid_ff | pop;
   assign have      = ~cmd_empty;
   assign tail_none = (cmd_data.tail == clx_pkg::TL_NONE);
   assign kw        = clx_pkg::kw_lookup(rd_data, cmd_data.word_len);
   assign kw_now    = kw.hit & ~cmd_data.word_ovf & (chunk_ff == '0);
   assign rem       = cmd_data.word_len - 6'({chunk_ff, 3'b000});
   assign last_chunk = (rem <= 6'd8);
   assign nbytes    = last_chunk ? rem[3:0] : 4'd8;
   assign word_end  = kw_now | last_chunk;

   always_comb begin
      chunk_text = '0;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < nbytes) begin
            chunk_text[8*b +: 8] = rd_data[8*b +: 8];
         end
      end
   end

   always_comb begin
      base            = '0;
      base.line_total = cmd_data.line_total;
      tail_res        = base;
      tail_res.last   = 1'b1;
      if (cmd_data.tail == clx_pkg::TL_END) begin
         tail_res.token_kind = clx_pkg::TOK_END;
      end else begin
         tail_res.token_kind  = clx_pkg::TOK_SYMBOL;
         tail_res.symbol_byte = cmd_data.sym;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clx_pkg::BK_IDLE: begin
            if (have) begin
               if (cmd_data.flush == clx_pkg::FL_WORD) begin
                  state_in = clx_pkg::BK_WORD;
               end else if ((cmd_data.flush == clx_pkg::FL_NUMBER) && !tail_none && adv) begin
                  state_in = clx_pkg::BK_TAIL;
               end
            end
         end
         clx_pkg::BK_WORD: begin
            if (adv && word_end) begin
               state_in = tail_none ? clx_pkg::BK_IDLE : clx_pkg::BK_TAIL;
            end
         end
         clx_pkg::BK_TAIL: begin
            if (adv) begin
               state_in = clx_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = clx_pkg::BK_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      load      = 1'b0;
      res       = base;
      cmd_pop   = 1'b0;
      word_done = 1'b0;
      chunk_in  = chunk_ff;
      case (state_ff)
         clx_pkg::BK_IDLE: begin
            if (have && adv) begin
               if (cmd_data.flush == clx_pkg::FL_NUMBER) begin
                  load                = 1'b1;
                  res.token_kind      = clx_pkg::TOK_NUMBER;
                  res.number_value    = cmd_data.num_value;
                  res.number_overflow = cmd_data.num_sat;
                  res.last            = tail_none;
                  cmd_pop             = tail_none;
               end else if (cmd_data.flush == clx_pkg::FL_NONE) begin
                  load    = 1'b1;
                  res     = tail_res;
                  cmd_pop = 1'b1;
               end
            end
         end
         clx_pkg::BK_WORD: begin
            if (adv) begin
               load = 1'b1;
               if (kw_now) begin
                  res.token_kind    = clx_pkg::TOK_KEYWORD;
                  res.keyword_index = kw.index;
               end else begin
                  res.token_kind     = clx_pkg::TOK_IDENT;
                  res.text_chunk     = chunk_text;
                  res.chunk_bytes    = nbytes;
                  res.word_truncated = cmd_data.word_ovf;
               end
               res.last = word_end & tail_none;
               if (word_end) begin
                  word_done = 1'b1;
                  cmd_pop   = tail_none;
                  chunk_in  = '0;
               end else begin
                  chunk_in = chunk_ff + ROW_W'(1);
               end
            end
         end
         clx_pkg::BK_TAIL: begin
            if (adv) begin
               load    = 1'b1;
               res     = tail_res;
               cmd_pop = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Address the row that the next cycle needs; read data is registered.
   assign rd_row   = chunk_in;
   assign valid_in = load | (valid_ff & ~pop);
   assign empty    = ~valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clx_pkg::BK_IDLE;
         chunk_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chunk_ff <= chunk_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   busy_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff != clx_pkg::BK_IDLE) |-> have)
      else $error("back busy without a queued command");

   pop_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (load && res.last))
      else $error("command retired without its last beat");

endmodule
